[sv/sgi_pkg.sv]
// Shared constants for the 2D segment intersection block.
// No dependencies; used by segment_intersection_2d_core, sgi_div and the sim files.
package sgi_pkg;
	// Coordinate width of every input and result field (Q16.16 by default).
	localparam int COORD_BITS = 32;
endpackage

[sv/sgi_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on sgi_pkg for its default width; carries a tag word alongside.
module sgi_div #(
	parameter int C  = sgi_pkg::COORD_BITS,
	parameter int TW = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [3*C:0]         num,
	input  logic [2*C:0]         den,
	input  logic [TW-1:0]        tag_in,
	output logic [C-1:0]         quot,
	output logic [TW-1:0]        tag_out
);
	localparam int MW = 2 * C + 1;

	// index 0 is the incoming item, index i the output of stage i
	logic [MW-1:0] rem_sd [0:C];
	logic [C-1:0]  low_sd [0:C];
	logic [C-1:0]  quo_sd [0:C];
	logic [MW-1:0] den_sd [0:C];
	logic [TW-1:0] tag_sd [0:C];

	// quotient is known to fit in C bits, so the top part is already below den
	assign rem_sd[0] = num[3*C:C];
	assign low_sd[0] = num[C-1:0];
	assign quo_sd[0] = '0;
	assign den_sd[0] = den;
	assign tag_sd[0] = tag_in;

	for (genvar i = 0; i < C; i++) begin : g_stage
		logic [MW:0]   trial;
		logic [MW:0]   diff;
		logic          ge;

		always_comb begin
			trial = {rem_sd[i], low_sd[i][C-1]};
			diff  = trial - {1'b0, den_sd[i]};
			ge    = (trial >= {1'b0, den_sd[i]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				tag_sd[i+1] <= '0;
			end else if (en) begin
				tag_sd[i+1] <= tag_sd[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1] <= ge ? diff[MW-1:0] : trial[MW-1:0];
				low_sd[i+1] <= {low_sd[i][C-2:0], 1'b0};
				quo_sd[i+1] <= {quo_sd[i][C-2:0], ge};
				den_sd[i+1] <= den_sd[i];
			end
		end
	end

	assign quot    = quo_sd[C];
	assign tag_out = tag_sd[C];
endmodule

[sv/segment_intersection_2d_core.sv]
// Top level of the exact 2D segment/segment crossing test.
// Depends on sgi_pkg and instantiates sgi_div once per axis.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------
//  in      | in_valid / in_ready  | a_start_x/y, a_end_x/y, b_start_x/y, b_end_x/y
//  out     | out_valid / out_ready| hit, cross_x, cross_y
//
// One item per cycle sustained while the output is not stalled. The pipe is
// stages 1 to 6, COORD_BITS divider stages (one quotient bit each), then stage 7.
// Reset (arst_n, async, active low) clears the valid bits and the divider tags.
// The whole pipe moves as one: it advances whenever the output register is
// empty or being taken, so a stall freezes every stage and nothing is lost.
// The arithmetic is scale invariant, so the coordinate format is only a naming.
module segment_intersection_2d_core #(
	parameter int COORD_BITS = sgi_pkg::COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic                         hit,
	output logic signed [COORD_BITS-1:0] cross_x,
	output logic signed [COORD_BITS-1:0] cross_y
);
	localparam int C  = COORD_BITS;
	localparam int MW = 2 * C + 1;   // magnitude of den / tn
	localparam int H  = C + 1;       // split point of tn for partial products
	localparam int PW = 3 * C + 1;   // tn * |s1|

	logic adv;

	// ---- stage 1: edge vectors and p0 - p2 ----
	logic              vld_s1;
	logic signed [C:0] s1x_s1, s1y_s1, s2x_s1, s2y_s1, dx_s1, dy_s1;
	logic [C-1:0]      p0x_s1, p0y_s1;

	// ---- stage 2: six products ----
	logic                  vld_s2;
	logic signed [2*C+1:0] da_s2, db_s2, sa_s2, sb_s2, ta_s2, tb_s2;
	logic signed [C:0]     s1x_s2, s1y_s2;
	logic [C-1:0]          p0x_s2, p0y_s2;

	// ---- stage 3: denominator and numerators ----
	logic                  vld_s3;
	logic signed [2*C+2:0] den_s3, sn_s3, tn_s3;
	logic signed [C:0]     s1x_s3, s1y_s3;
	logic [C-1:0]          p0x_s3, p0y_s3;

	// ---- stage 4: sign normalised, range test ----
	logic              vld_s4, hit_s4, negx_s4, negy_s4;
	logic [MW-1:0]     den_s4, tn_s4;
	logic [C-1:0]      mx_s4, my_s4, p0x_s4, p0y_s4;

	// ---- stage 5: partial products of tn * |s1| ----
	logic              vld_s5, hit_s5, negx_s5, negy_s5;
	logic [2*C:0]      plx_s5, ply_s5;
	logic [2*C-1:0]    phx_s5, phy_s5;
	logic [MW-1:0]     den_s5;
	logic [C-1:0]      p0x_s5, p0y_s5;

	// ---- stage 6: full products ----
	logic              vld_s6, hit_s6, negx_s6, negy_s6;
	logic [PW-1:0]     px_s6, py_s6;
	logic [MW-1:0]     den_s6;
	logic [C-1:0]      p0x_s6, p0y_s6;

	// ---- divider outputs ----
	logic [C-1:0]      qx, qy;
	logic [C+2:0]      tagx;
	logic [C:0]        tagy;

	// ---- stage 7: output register ----
	logic              vld_s7, hit_s7;
	logic [C-1:0]      cx_s7, cy_s7;

	assign adv      = !vld_s7 || out_ready;
	assign in_ready = adv;

	// stage 4 combinational
	logic                  neg_d;
	logic signed [2*C+2:0] den_a, sn_a, tn_a;
	logic signed [C:0]     ax, ay;
	logic                  hit_d;

	always_comb begin
		neg_d = den_s3[2*C+2];
		den_a = neg_d ? -den_s3 : den_s3;
		sn_a  = neg_d ? -sn_s3 : sn_s3;
		tn_a  = neg_d ? -tn_s3 : tn_s3;
		hit_d = (den_s3 != '0) && !sn_a[2*C+2] && (sn_a <= den_a)
			&& !tn_a[2*C+2] && (tn_a <= den_a);
		ax    = s1x_s3[C] ? -s1x_s3 : s1x_s3;
		ay    = s1y_s3[C] ? -s1y_s3 : s1y_s3;
	end

	// stage 7 combinational: apply sign, add p0, saturate
	logic signed [C+1:0] vx, vy;
	logic [C-1:0]        satx, saty;
	localparam logic [C-1:0] MAXV = {1'b0, {(C-1){1'b1}}};
	localparam logic [C-1:0] MINV = {1'b1, {(C-1){1'b0}}};

	always_comb begin
		vx = {{2{tagx[C-1]}}, tagx[C-1:0]}
			+ (tagx[C] ? -{2'b00, qx} : {2'b00, qx});
		vy = {{2{tagy[C-1]}}, tagy[C-1:0]}
			+ (tagy[C] ? -{2'b00, qy} : {2'b00, qy});
		if (vx[C+1:C-1] == 3'b000 || vx[C+1:C-1] == 3'b111)
			satx = vx[C-1:0];
		else
			satx = vx[C+1] ? MINV : MAXV;
		if (vy[C+1:C-1] == 3'b000 || vy[C+1:C-1] == 3'b111)
			saty = vy[C-1:0];
		else
			saty = vy[C+1] ? MINV : MAXV;
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= tagx[C+2];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (adv) begin
			// s1
			s1x_s1 <= {a_end_x[C-1], a_end_x} - {a_start_x[C-1], a_start_x};
			s1y_s1 <= {a_end_y[C-1], a_end_y} - {a_start_y[C-1], a_start_y};
			s2x_s1 <= {b_end_x[C-1], b_end_x} - {b_start_x[C-1], b_start_x};
			s2y_s1 <= {b_end_y[C-1], b_end_y} - {b_start_y[C-1], b_start_y};
			dx_s1  <= {a_start_x[C-1], a_start_x} - {b_start_x[C-1], b_start_x};
			dy_s1  <= {a_start_y[C-1], a_start_y} - {b_start_y[C-1], b_start_y};
			p0x_s1 <= a_start_x;
			p0y_s1 <= a_start_y;
			// s2
			da_s2  <= s1x_s1 * s2y_s1;
			db_s2  <= s2x_s1 * s1y_s1;
			sa_s2  <= s1x_s1 * dy_s1;
			sb_s2  <= s1y_s1 * dx_s1;
			ta_s2  <= s2x_s1 * dy_s1;
			tb_s2  <= s2y_s1 * dx_s1;
			s1x_s2 <= s1x_s1;
			s1y_s2 <= s1y_s1;
			p0x_s2 <= p0x_s1;
			p0y_s2 <= p0y_s1;
			// s3
			den_s3 <= {da_s2[2*C+1], da_s2} - {db_s2[2*C+1], db_s2};
			sn_s3  <= {sa_s2[2*C+1], sa_s2} - {sb_s2[2*C+1], sb_s2};
			tn_s3  <= {ta_s2[2*C+1], ta_s2} - {tb_s2[2*C+1], tb_s2};
			s1x_s3 <= s1x_s2;
			s1y_s3 <= s1y_s2;
			p0x_s3 <= p0x_s2;
			p0y_s3 <= p0y_s2;
			// s4
			hit_s4  <= hit_d;
			den_s4  <= den_a[MW-1:0];
			tn_s4   <= tn_a[MW-1:0];
			negx_s4 <= s1x_s3[C];
			negy_s4 <= s1y_s3[C];
			mx_s4   <= ax[C-1:0];
			my_s4   <= ay[C-1:0];
			p0x_s4  <= p0x_s3;
			p0y_s4  <= p0y_s3;
			// s5
			plx_s5  <= {1'b0, tn_s4[H-1:0]} * {1'b0, mx_s4};
			ply_s5  <= {1'b0, tn_s4[H-1:0]} * {1'b0, my_s4};
			phx_s5  <= tn_s4[MW-1:H] * mx_s4;
			phy_s5  <= tn_s4[MW-1:H] * my_s4;
			hit_s5  <= hit_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			den_s5  <= den_s4;
			p0x_s5  <= p0x_s4;
			p0y_s5  <= p0y_s4;
			// s6
			px_s6   <= {{(PW-2*C-1){1'b0}}, plx_s5} + {phx_s5, {H{1'b0}}};
			py_s6   <= {{(PW-2*C-1){1'b0}}, ply_s5} + {phy_s5, {H{1'b0}}};
			hit_s6  <= hit_s5;
			negx_s6 <= negx_s5;
			negy_s6 <= negy_s5;
			den_s6  <= den_s5;
			p0x_s6  <= p0x_s5;
			p0y_s6  <= p0y_s5;
			// s7: masked to zero when there is no crossing
			hit_s7  <= tagx[C+1];
			cx_s7   <= tagx[C+1] ? satx : '0;
			cy_s7   <= tagx[C+1] ? saty : '0;
		end
	end

	// tag x: {valid, hit, sign of s1x, p0x}; tag y: {sign of s1y, p0y}
	sgi_div #(.C(C), .TW(C + 3)) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.num     (px_s6),
		.den     (den_s6),
		.tag_in  ({vld_s6, hit_s6, negx_s6, p0x_s6}),
		.quot    (qx),
		.tag_out (tagx)
	);

	sgi_div #(.C(C), .TW(C + 1)) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.num     (py_s6),
		.den     (den_s6),
		.tag_in  ({negy_s6, p0y_s6}),
		.quot    (qy),
		.tag_out (tagy)
	);

	assign out_valid = vld_s7;
	assign hit       = hit_s7;
	assign cross_x   = cx_s7;
	assign cross_y   = cy_s7;
endmodule

[sim/sgi_checker.sv]
// Checker for segment_intersection_2d_core: watches both channels, predicts each crossing
// result from the accepted segment pair and compares it field by field. Depends on sgi_pkg.
module sgi_checker #(
	parameter int COORD_BITS = sgi_pkg::COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] a_start_x,
	input  logic signed [COORD_BITS-1:0] a_start_y,
	input  logic signed [COORD_BITS-1:0] a_end_x,
	input  logic signed [COORD_BITS-1:0] a_end_y,
	input  logic signed [COORD_BITS-1:0] b_start_x,
	input  logic signed [COORD_BITS-1:0] b_start_y,
	input  logic signed [COORD_BITS-1:0] b_end_x,
	input  logic signed [COORD_BITS-1:0] b_end_y,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic                         hit,
	input  logic signed [COORD_BITS-1:0] cross_x,
	input  logic signed [COORD_BITS-1:0] cross_y,
	output int                           fail_count,
	output int                           pending,
	output int                           hits_seen,
	output int                           results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [159:0] wide_t;
	typedef struct packed {
		logic                         hit;
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} crossing_t;

	crossing_t crossings_due[$];

	// p0 + trunc(tn*s/den) on one axis, saturated to the coordinate range
	function automatic logic signed [COORD_BITS-1:0] axis_point(wide_t p0, wide_t s,
			wide_t tn, wide_t den);
		wide_t prod, mag, q, v, hi, lo;
		prod = tn * s;
		mag = prod < 0 ? -prod : prod;
		q = mag / den;
		v = p0 + (prod < 0 ? -q : q);
		hi = (wide_t'(1) <<< (COORD_BITS - 1)) - 1;
		lo = -(wide_t'(1) <<< (COORD_BITS - 1));
		if (v > hi) return hi[COORD_BITS-1:0];
		if (v < lo) return lo[COORD_BITS-1:0];
		return v[COORD_BITS-1:0];
	endfunction

	function automatic crossing_t predict_crossing();
		crossing_t r;
		wide_t p0x, p0y, s1x, s1y, s2x, s2y, dx, dy, den, sn, tn;
		p0x = a_start_x; p0y = a_start_y;
		s1x = wide_t'(a_end_x) - p0x;
		s1y = wide_t'(a_end_y) - p0y;
		s2x = wide_t'(b_end_x) - wide_t'(b_start_x);
		s2y = wide_t'(b_end_y) - wide_t'(b_start_y);
		dx = p0x - wide_t'(b_start_x);
		dy = p0y - wide_t'(b_start_y);
		den = s1x * s2y - s2x * s1y;
		sn = s1x * dy - s1y * dx;
		tn = s2x * dy - s2y * dx;
		r = '0;
		// parallel, collinear or zero-length: no crossing
		if (den == 0) return r;
		if (den < 0) begin
			den = -den; sn = -sn; tn = -tn;
		end
		// endpoints touching (s or t exactly 0 or 1) still count
		if (sn < 0 || sn > den || tn < 0 || tn > den) return r;
		r.hit = 1'b1;
		r.x = axis_point(p0x, s1x, tn, den);
		r.y = axis_point(p0y, s1y, tn, den);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		crossing_t want;
		if (!arst_n) begin
			fail_count <= 0;
			hits_seen <= 0;
			results_seen <= 0;
			pending <= 0;
			crossings_due.delete();
		end else begin
			if (in_valid && in_ready)
				crossings_due.push_back(predict_crossing());
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (hit) hits_seen <= hits_seen + 1;
				if (crossings_due.size() == 0) begin
					$display("%0t: result with none expected: hit=%0b x=%0d y=%0d",
						$time, hit, cross_x, cross_y);
					fail_count <= fail_count + 1;
				end else begin
					want = crossings_due.pop_front();
					if (want.hit !== hit || want.x !== cross_x || want.y !== cross_y) begin
						$display("%0t: mismatch expected hit=%0b x=%0d y=%0d actual hit=%0b x=%0d y=%0d",
							$time, want.hit, want.x, want.y, hit, cross_x, cross_y);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= crossings_due.size();
		end
	end
endmodule

[sim/tb_segment_intersection_2d_core.sv]
// Testbench top for segment_intersection_2d_core: drives segment pairs, stalls the output,
// and gives the verdict from the failure and pending counts of sgi_checker. Depends on sgi_pkg.
module tb_segment_intersection_2d_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CB = sgi_pkg::COORD_BITS;
	localparam int LATENCY = 7 + CB;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [CB-1:0] MAXC = {1'b0, {(CB-1){1'b1}}};
	localparam logic signed [CB-1:0] MINC = {1'b1, {(CB-1){1'b0}}};
	localparam logic signed [CB-1:0] ONE = 1 <<< 16;	// 1.0 in Q16.16

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0, hit;
	logic signed [CB-1:0] a_start_x = 0, a_start_y = 0, a_end_x = 0, a_end_y = 0;
	logic signed [CB-1:0] b_start_x = 0, b_start_y = 0, b_end_x = 0, b_end_y = 0;
	logic signed [CB-1:0] cross_x, cross_y;
	int fail_count, pending, hits_seen, results_seen;

	// idle odds in percent; hold_off forces a long output stall
	int send_idle = 6, take_idle = 56;
	bit hold_off = 0;
	int cycles = 0;

	segment_intersection_2d_core i_dut (.*);

	sgi_checker i_chk (.*);

	initial forever #6 clk = ~clk;

	// cycle limit: a hang anywhere ends the run as a failure
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, overridden by a hold-off stretch
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= !hold_off && ($urandom_range(99) >= take_idle);
	end

	// offer one segment pair and wait until the block takes it; valid stays up
	// when the next pair follows straight on
	task automatic send_pair(input logic signed [CB-1:0] ax0, ay0, ax1, ay1,
			bx0, by0, bx1, by1);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		a_start_x <= ax0; a_start_y <= ay0; a_end_x <= ax1; a_end_y <= ay1;
		b_start_x <= bx0; b_start_y <= by0; b_end_x <= bx1; b_end_y <= by1;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic logic signed [CB-1:0] rand_coord(int kind);
		case (kind)
			0: return $urandom;	// full range, all bits
			1: return $signed($urandom_range(8 * ONE)) - 4 * ONE;
			2: return $urandom_range(1) ? MAXC - $urandom_range(3) : MINC + $urandom_range(3);
			default: return $signed($urandom_range(40)) - 20;
		endcase
	endfunction

	// a pair built to cross: B runs through a point chosen on A
	task automatic send_crossing(int kind);
		logic signed [CB-1:0] ax0, ay0, ax1, ay1, mx, my, dx, dy;
		ax0 = rand_coord(kind); ay0 = rand_coord(kind);
		ax1 = rand_coord(kind); ay1 = rand_coord(kind);
		mx = ax0 + ((ax1 >>> 1) - (ax0 >>> 1));
		my = ay0 + ((ay1 >>> 1) - (ay0 >>> 1));
		dx = $signed($urandom_range(2000)) - 1000;
		dy = $signed($urandom_range(2000)) - 1000;
		send_pair(ax0, ay0, ax1, ay1, mx - dx, my - dy, mx + dx, my + dy);
	endtask

	task automatic send_random(int n);
		int kind;
		repeat (n) begin
			kind = $urandom_range(3);
			if ($urandom_range(99) < 65)
				send_crossing(kind);
			else
				send_pair(rand_coord(kind), rand_coord(kind), rand_coord(kind),
					rand_coord(kind), rand_coord(kind), rand_coord(kind),
					rand_coord(kind), rand_coord(kind));
		end
	endtask

	task automatic drain();
		in_valid <= 0;
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: plain cross, touching ends, T junction, parallel, collinear
		// overlap, zero length, miss, and the extremes of the range
		send_pair(0, 0, 2 * ONE, 2 * ONE, 0, 2 * ONE, 2 * ONE, 0);
		send_pair(0, 0, ONE, 0, ONE, 0, ONE, ONE);
		send_pair(0, 0, ONE, 0, 0, 0, 0, ONE);
		send_pair(0, 0, 2 * ONE, 0, ONE, 0, ONE, ONE);
		send_pair(0, 0, ONE, ONE, 0, ONE, ONE, 2 * ONE);
		send_pair(0, 0, 2 * ONE, 0, ONE, 0, 3 * ONE, 0);
		send_pair(ONE, ONE, ONE, ONE, 0, 0, 2 * ONE, 2 * ONE);
		send_pair(0, 0, 0, 0, 0, 0, 0, 0);
		send_pair(0, 0, ONE, 0, 2 * ONE, -ONE, 2 * ONE, ONE);
		send_pair(0, 0, ONE, ONE, ONE, 0, 2 * ONE, -ONE);
		send_pair(MINC, MINC, MAXC, MAXC, MINC, MAXC, MAXC, MINC);
		send_pair(MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC, MAXC);
		send_pair(MINC, 0, MAXC, 0, 0, MINC, 0, MAXC);
		send_pair(MAXC, MAXC, MINC, MINC, MAXC, MINC, MINC, MAXC);
		send_pair(MINC, MINC, MINC, MAXC, MINC, MINC, MAXC, MINC);
		send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
		send_pair(0, 0, 3, 0, 1, -1, 2, 1);
		send_pair(-1, 0, -1, -1, -1, -1, 0, 0);

		send_random(380);
		// sender pauses until every result is in
		drain();

		send_idle = 56; take_idle = 6;
		send_random(380);

		// long receiver hold-off while items keep coming, so the pipe fills
		fork
			begin
				hold_off = 1;
				repeat (3 * LATENCY) @(posedge clk);
				hold_off = 0;
			end
			send_random(90);
		join

		send_idle = 0; take_idle = 0;
		send_random(360);

		drain();
		repeat (LATENCY + 5) @(posedge clk);
		$display("covered %0d segment pairs, %0d crossings, with stalls on both sides",
			results_seen, hits_seen);
		if (fail_count == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
